// File: rtl/core/bdai_pkg.sv
package bdai_pkg;

  // Sizes and limits
  localparam int unsigned MaxDepth   = 31;
  localparam int unsigned DepthBits  = 5;
  localparam int unsigned ColumnBits = 10;
  localparam int unsigned MaxPadding = 63;
  localparam int unsigned PadBits    = 6;
  localparam int unsigned TabStep    = 8;
  localparam int unsigned TabShift   = 3;

  localparam logic [ColumnBits-1:0] ColLimit = '1;

  // Operation codes
  localparam logic [1:0] OP_CHAR      = 2'd0;
  localparam logic [1:0] OP_DEEPER    = 2'd1;
  localparam logic [1:0] OP_SHALLOWER = 2'd2;
  localparam logic [1:0] OP_CLOSE     = 2'd3;

  // Character codes
  localparam logic [7:0] CH_ALIGN  = 8'h01;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Continuation codes
  localparam logic [1:0] CONT_NONE   = 2'd0;
  localparam logic [1:0] CONT_BSLASH = 2'd1;
  localparam logic [1:0] CONT_LINE   = 2'd2;

  // What an accepted beat needs after the accept cycle
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_CHAR,
    CLS_NL
  } item_cls_e;

  typedef struct packed {
    logic accept;
    logic prep;
    logic emit_pad;
    logic emit_char;
    logic emit_nl;
  } dp_cmd_t;

  typedef struct packed {
    item_cls_e cls;
    logic      pad_done;
    logic      out_free;
  } dp_status_t;

  // Saturate a column value one bit wider than a column
  function automatic logic [ColumnBits-1:0] col_sat(input logic [ColumnBits:0] v);
    logic [ColumnBits-1:0] r;
    if (v > {1'b0, ColLimit}) begin
      r = ColLimit;
    end else begin
      r = v[ColumnBits-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/bracket_depth_auto_indenter_core.sv
// Bracket-depth auto-indenter.
// Input channel (in_valid_i/in_ready_o) takes one beat of operation_i and
// in_char_i: character, deeper, shallower or close. Output channel
// (out_valid_o/out_ready_i) gives the bytes that beat causes, one per beat,
// with last_o high on the final one; beats that cause nothing give none.
// Sequence: a beat is taken when in_valid_i meets in_ready_o. Deeper, shallower, close on an empty
// line, blanks and the alignment mark then free the input the next cycle.
// A newline, or a close that ends a line, then waits in S_NL to send the
// newline byte. A visible character goes from the accept cycle to S_PREP,
// which sizes its padding, then S_EMIT sends each padding byte (at most 63)
// and then the character. The output register sends one byte per cycle while
// the receiver is ready; the controller works on one beat at a time.
// A stalled receiver holds the output register and the sequencer waits on
// it; the next beat is accepted once the current one is fully handed over
// to the output register.
// Reset clears depth, both columns and the continuation state, and empties
// the output register.
module bracket_depth_auto_indenter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_o
);
  import bdai_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bdai_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bdai_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (operation_i),
    .in_char_i   (in_char_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.prep, cmd.emit_pad, cmd.emit_char, cmd.emit_nl}))
    else $error("more than one datapath command");

  // A byte is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_pad || cmd.emit_char || cmd.emit_nl) |-> status.out_free)
    else $error("byte loaded over a held output");

  // Depth changes emit nothing and leave the input open
  a_depth_op_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o
     && (operation_i == OP_DEEPER || operation_i == OP_SHALLOWER)) |=> in_ready_o)
    else $error("depth operation blocked the input");

  // The input closes only after taking a beat
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("input closed without a beat");

endmodule

// File: rtl/core/bdai_ctrl.sv
module bdai_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bdai_pkg::dp_status_t status_i,
  output bdai_pkg::dp_cmd_t    cmd_o
);
  import bdai_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_NL   = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          case (status_i.cls)
            CLS_CHAR: state_d = S_PREP;
            CLS_NL:   state_d = S_NL;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          if (!status_i.pad_done) begin
            cmd_o.emit_pad = 1'b1;
          end else begin
            cmd_o.emit_char = 1'b1;
            state_d         = S_IDLE;
          end
        end
      end
      S_NL: begin
        if (status_i.out_free) begin
          cmd_o.emit_nl = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/bdai_datapath.sv
module bdai_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           operation_i,
  input  logic [7:0]           in_char_i,
  input  bdai_pkg::dp_cmd_t    cmd_i,
  output bdai_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 last_o
);
  import bdai_pkg::*;

  localparam int unsigned ColW1   = ColumnBits + 1;
  localparam int unsigned TabBits = ColumnBits - TabShift;

  // Block state
  logic [DepthBits-1:0]  depth_q, depth_d;
  logic [ColumnBits-1:0] icol_q, icol_d;
  logic [ColumnBits-1:0] ocol_q, ocol_d;
  logic [1:0]            cont_q, cont_d;
  // Latched beat and padding counters
  logic [7:0]            ch_q, ch_d;
  logic                  close_q, close_d;
  logic [PadBits-1:0]    tab_cnt_q, tab_cnt_d;
  logic [PadBits-1:0]    sp_cnt_q, sp_cnt_d;
  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic                  ocol_zero;
  logic                  out_free;
  item_cls_e             cls;
  logic [DepthBits-1:0]  depth_dec;
  logic [ColW1-1:0]      mark;
  logic [ColW1-1:0]      indent;
  logic [TabBits-1:0]    tabs_raw;
  logic [ColumnBits-1:0] sp_raw;
  logic [PadBits-1:0]    tab_c;
  logic [PadBits-1:0]    pad_room;
  logic [ColumnBits-1:0] icol_inc;

  assign ocol_zero = (ocol_q == '0);
  assign out_free  = !out_valid_q || out_ready_i;

  // Classify the beat at the input
  always_comb begin
    cls = CLS_NONE;
    case (operation_i)
      OP_CHAR: begin
        if (in_char_i == CH_NL) begin
          cls = CLS_NL;
        end else if (in_char_i inside {CH_SPACE, CH_TAB, CH_ALIGN}) begin
          cls = CLS_NONE;
        end else begin
          cls = CLS_CHAR;
        end
      end
      OP_CLOSE: cls = ocol_zero ? CLS_NONE : CLS_NL;
      default:  cls = CLS_NONE;
    endcase
  end

  assign status_o.cls      = cls;
  assign status_o.pad_done = (tab_cnt_q == '0) && (sp_cnt_q == '0);
  assign status_o.out_free = out_free;

  // Column arithmetic for the accept path and the character emit
  always_comb begin
    if ((in_char_i inside {CH_RPAREN, CH_RBRACK, CH_RBRACE}) && (depth_q != '0)) begin
      depth_dec = depth_q - 1'b1;
    end else begin
      depth_dec = depth_q;
    end
    mark     = (ColW1'(depth_q) << TabShift) + ColW1'(2 * TabStep);
    indent   = ColW1'(depth_dec) << TabShift;
    icol_inc = col_sat({1'b0, icol_q} + ColW1'(1));
  end

  // Padding split: tabs only at line start, total capped
  always_comb begin
    if (ocol_zero) begin
      tabs_raw = icol_q[ColumnBits-1:TabShift];
      sp_raw   = ColumnBits'(icol_q[TabShift-1:0]);
    end else begin
      tabs_raw = '0;
      sp_raw   = icol_q - ocol_q;
    end
    if (tabs_raw > TabBits'(MaxPadding)) begin
      tab_c = PadBits'(MaxPadding);
    end else begin
      tab_c = PadBits'(tabs_raw);
    end
    pad_room = PadBits'(MaxPadding) - tab_c;
  end

  // State updates per command
  always_comb begin
    depth_d     = depth_q;
    icol_d      = icol_q;
    ocol_d      = ocol_q;
    cont_d      = cont_q;
    ch_d        = ch_q;
    close_d     = close_q;
    tab_cnt_d   = tab_cnt_q;
    sp_cnt_d    = sp_cnt_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    if (cmd_i.accept) begin
      ch_d    = in_char_i;
      close_d = (operation_i == OP_CLOSE);
      case (operation_i)
        OP_DEEPER: begin
          if (depth_q < DepthBits'(MaxDepth)) depth_d = depth_q + 1'b1;
        end
        OP_SHALLOWER: begin
          if (depth_q != '0) depth_d = depth_q - 1'b1;
        end
        OP_CLOSE: begin
          if (ocol_zero) begin
            depth_d = '0;
            icol_d  = '0;
            ocol_d  = '0;
            cont_d  = CONT_NONE;
          end
        end
        default: begin
          if (in_char_i == CH_SPACE) begin
            if (!ocol_zero) icol_d = icol_inc;
          end else if (in_char_i == CH_TAB) begin
            if (!ocol_zero) begin
              icol_d = col_sat({1'b0, icol_q[ColumnBits-1:TabShift], TabShift'(0)}
                               + ColW1'(TabStep));
            end
          end else if (in_char_i == CH_ALIGN) begin
            if (!ocol_zero) begin
              if ({1'b0, icol_q} >= mark) begin
                icol_d = icol_inc;
              end else begin
                icol_d = col_sat(mark);
              end
            end
          end else if (in_char_i != CH_NL) begin
            // Closing brackets drop a level before they are placed
            depth_d = depth_dec;
            if (ocol_zero && (in_char_i != CH_HASH) && (cont_q != CONT_LINE)) begin
              icol_d = col_sat({1'b0, icol_q} + indent);
            end
          end
        end
      endcase
    end

    if (cmd_i.prep) begin
      tab_cnt_d = tab_c;
      sp_cnt_d  = (sp_raw > ColumnBits'(pad_room)) ? pad_room : PadBits'(sp_raw);
    end

    // Tabs go out before spaces
    if (cmd_i.emit_pad) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b0;
      if (tab_cnt_q != '0) begin
        out_char_d = CH_TAB;
        tab_cnt_d  = tab_cnt_q - 1'b1;
      end else begin
        out_char_d = CH_SPACE;
        sp_cnt_d   = sp_cnt_q - 1'b1;
      end
    end

    if (cmd_i.emit_char) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b1;
      out_char_d  = ch_q;
      icol_d      = icol_inc;
      ocol_d      = icol_inc;
      cont_d      = (ch_q == CH_BSLASH) ? CONT_BSLASH : CONT_NONE;
      // Opening brackets raise the level after they are placed
      if ((ch_q inside {CH_LPAREN, CH_LBRACK, CH_LBRACE})
          && (depth_q < DepthBits'(MaxDepth))) begin
        depth_d = depth_q + 1'b1;
      end
    end

    if (cmd_i.emit_nl) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b1;
      out_char_d  = CH_NL;
      icol_d      = '0;
      ocol_d      = '0;
      if (close_q) begin
        depth_d = '0;
        cont_d  = CONT_NONE;
      end else begin
        cont_d = (cont_q == CONT_BSLASH) ? CONT_LINE : CONT_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      icol_q      <= '0;
      ocol_q      <= '0;
      cont_q      <= CONT_NONE;
      tab_cnt_q   <= '0;
      sp_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      icol_q      <= icol_d;
      ocol_q      <= ocol_d;
      cont_q      <= cont_d;
      tab_cnt_q   <= tab_cnt_d;
      sp_cnt_q    <= sp_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    close_q    <= close_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

endmodule
